// ===== rtl/slm_pkg.sv =====
// Shared types, constants and helper functions of the segment lock manager.
package slm_pkg;

   localparam int SEGMENTS = 128;
   localparam int SLOTS    = 4;
   localparam int LIST_MAX = 16;

   localparam int SEG_AW      = $clog2(SEGMENTS);
   localparam int CNT_W       = $clog2(LIST_MAX + 1);
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCNT_W      = $clog2(SLOTS + 1);
   localparam int BUF_N       = SLOTS + 1;
   localparam int BUF_W       = $clog2(BUF_N);
   localparam int LMEM_DEPTH  = BUF_N * 2 * LIST_MAX;
   localparam int LMEM_AW     = $clog2(LMEM_DEPTH);

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FAIL = 2'd1;

   typedef enum logic [2:0] {
      CMD_ASK          = 3'd0,
      CMD_CLAIM_ALL    = 3'd1,
      CMD_CLAIM_FIRST  = 3'd2,
      CMD_CLAIM_EITHER = 3'd3,
      CMD_RELEASE      = 3'd4,
      CMD_RELEASE_ALL  = 3'd5,
      CMD_REGISTER     = 3'd6,
      CMD_TIMER        = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      W_IDLE       = 3'd0,
      W_REL        = 3'd1,
      W_TMR        = 3'd2,
      W_EITHER_REL = 3'd3,
      W_EITHER_TMR = 3'd4
   } wmode_type;

   typedef enum logic [1:0] {K_ALL, K_FIRST, K_EITHER} kind_type;
   typedef enum logic [1:0] {P_CHECK, P_LOCK, P_FIRST, P_REL} pass_type;
   typedef enum logic [1:0] {PU_REQ, PU_REL, PU_TMR} purpose_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_ASK, ST_WLIST, ST_WSEG, ST_WOWN, ST_PASS_END,
      ST_CLAIM_DONE, ST_SLOT, ST_SCAN_RD, ST_SCAN_EV, ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        with_timeout;
      logic [6:0]  train_owner;
      logic [1:0]  train_slot;
      logic [7:0]  requester;
      logic        list_sel;
      logic [6:0]  segment;
      logic        last_item;
      logic [15:0] timeout_ticks;
   } req_type;

   typedef struct packed {
      logic [7:0]  reply_tag;
      logic [1:0]  status;
      logic        has_value;
      logic [6:0]  granted_value;
      logic        start_timer;
      logic [1:0]  timer_slot;
      logic [15:0] timer_ticks;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_emit_type;

   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [SEG_AW-1:0] addr;
      logic [6:0]        wdata;
   } own_port_type;

   typedef struct packed {
      logic               rd;
      logic               wr;
      logic [LMEM_AW-1:0] raddr;
      logic [LMEM_AW-1:0] waddr;
      logic [6:0]         wdata;
   } list_port_type;

   function automatic logic seg_in_range(logic [6:0] s);
      return int'(s) < SEGMENTS;
   endfunction

   function automatic logic [SEG_AW-1:0] seg_addr(logic [6:0] s);
      int v;
      v = int'(s);
      return SEG_AW'(v);
   endfunction

   function automatic logic [LMEM_AW-1:0] list_addr(logic [BUF_W-1:0] b, logic h,
                                                    logic [CNT_W-1:0] i);
      int a;
      a = int'(b) * 2 * LIST_MAX + int'(h) * LIST_MAX + int'(i);
      return LMEM_AW'(a);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(logic [1:0] t);
      int v;
      v = int'(t);
      for (int n = 0; n < 4; n++) begin
         if (v >= SLOTS) v = v - SLOTS;
      end
      return SLOT_W'(v);
   endfunction

   function automatic kind_type waiter_kind(wmode_type m, logic needs_all);
      if (m == W_EITHER_REL || m == W_EITHER_TMR) return K_EITHER;
      return needs_all ? K_ALL : K_FIRST;
   endfunction

endpackage

// ===== rtl/slm_owner_mem.sv =====
// Segment owner table: synchronous RAM with per-entry valid bits for reset.
module slm_owner_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  slm_pkg::own_port_type port,
   output logic [6:0]           rdata
);

   logic [6:0]                  mem [slm_pkg::SEGMENTS];
   logic [slm_pkg::SEGMENTS-1:0] valid_ff;
   logic [6:0]                  data_ff;
   logic                        vbit_ff;

   always_ff @(posedge clock) begin
      if (port.wr) mem[port.addr] <= port.wdata;
      if (port.rd) begin
         data_ff <= mem[port.addr];
         vbit_ff <= valid_ff[port.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (port.wr) begin
         valid_ff[port.addr] <= 1'b1;
      end
   end

   // an entry never written reads as free
   assign rdata = vbit_ff ? data_ff : 7'd0;

endmodule

// ===== rtl/slm_list_mem.sv =====
// Segment list buffers: request list and parked waiter lists in one RAM.
module slm_list_mem (
   input  logic                  clock,
   input  slm_pkg::list_port_type port,
   output logic [6:0]            rdata
);

   logic [6:0] mem [slm_pkg::LMEM_DEPTH];
   logic [6:0] data_ff;

   always_ff @(posedge clock) begin
      if (port.wr) mem[port.waddr] <= port.wdata;
      if (port.rd) data_ff <= mem[port.raddr];
   end

   assign rdata = data_ff;

endmodule

// ===== rtl/slm_ctrl.sv =====
// Command sequencer: list walks, claims, releases, waiter slots and result queueing.
module slm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  slm_pkg::req_type      req_data,
   output logic                  busy,
   output slm_pkg::rsp_emit_type emit,
   output slm_pkg::own_port_type own_port,
   input  logic [6:0]            own_rdata,
   output slm_pkg::list_port_type lst_port,
   input  logic [6:0]            lst_rdata
);

   localparam int CW = slm_pkg::CNT_W;
   localparam int SW = slm_pkg::SLOT_W;
   localparam int BW = slm_pkg::BUF_W;
   localparam int SCNT_W_L = slm_pkg::SCNT_W;

   slm_pkg::state_type   state_ff, state_in;

   // latched request
   slm_pkg::cmd_type     cmd_ff;
   logic                 to_ff;
   logic [6:0]           own_ff;
   logic [SW-1:0]        slot_ff;
   logic [7:0]           tag_ff;
   logic [6:0]           seg_ff;
   logic [15:0]          ticks_ff;

   // request list bookkeeping
   logic [BW-1:0]        req_buf_ff;
   logic [CW-1:0]        req_cnt_ff [2];

   // waiter slots
   slm_pkg::wmode_type   wmode_ff [slm_pkg::SLOTS];
   logic                 wall_ff  [slm_pkg::SLOTS];
   logic [6:0]           wown_ff  [slm_pkg::SLOTS];
   logic [7:0]           wtag_ff  [slm_pkg::SLOTS];
   logic [CW-1:0]        wcnt_ff  [slm_pkg::SLOTS][2];
   logic [BW-1:0]        wbuf_ff  [slm_pkg::SLOTS];

   // list walker
   logic [BW-1:0]        w_buf_ff;
   logic                 w_half_ff;
   logic [CW-1:0]        w_i_ff;
   logic [CW-1:0]        w_na_ff;
   logic [CW-1:0]        w_nb_ff;
   logic [6:0]           w_own_ff;
   slm_pkg::kind_type    kind_ff;
   slm_pkg::pass_type    pass_ff;
   slm_pkg::purpose_type purpose_ff;
   logic                 hit_ff;
   logic [6:0]           cur_seg_ff;
   logic                 ok_ff;
   logic                 hasv_ff;
   logic [6:0]           val_ff;
   logic [SCNT_W_L-1:0]  k_ff;
   logic [slm_pkg::SEG_AW-1:0] j_ff;

   // held result, so the final one of a command can be marked
   slm_pkg::rsp_type     pend_ff;
   logic                 pend_v_ff;

   logic                 accept;
   logic [CW-1:0]        sel_cnt;
   logic                 collect;
   logic [CW-1:0]        w_n;
   logic                 seg_free;
   logic                 walk_stop;
   logic [SW-1:0]        kx;
   logic                 slot_cond;
   logic                 scan_end;
   logic                 produce;
   slm_pkg::rsp_type     prod;
   slm_pkg::kind_type    start_kind;

   assign busy      = (state_ff != slm_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign sel_cnt   = req_cnt_ff[req_data.list_sel];
   assign collect   = accept && slm_pkg::seg_in_range(req_data.segment) &&
                      (sel_cnt < CW'(slm_pkg::LIST_MAX));
   assign w_n       = w_half_ff ? w_nb_ff : w_na_ff;
   assign seg_free  = slm_pkg::seg_in_range(cur_seg_ff) &&
                      (own_rdata == 7'd0 || own_rdata == w_own_ff);
   assign walk_stop = (pass_ff == slm_pkg::P_CHECK && !seg_free) ||
                      (pass_ff == slm_pkg::P_FIRST && seg_free);
   assign kx        = k_ff[SW-1:0];
   assign slot_cond = (wown_ff[kx] != own_ff) &&
                      (wmode_ff[kx] == slm_pkg::W_REL || wmode_ff[kx] == slm_pkg::W_EITHER_REL);
   assign scan_end  = (j_ff == slm_pkg::SEG_AW'(slm_pkg::SEGMENTS - 1));

   always_comb begin
      unique case (cmd_ff)
         slm_pkg::CMD_CLAIM_ALL:   start_kind = slm_pkg::K_ALL;
         slm_pkg::CMD_CLAIM_FIRST: start_kind = slm_pkg::K_FIRST;
         default:                  start_kind = slm_pkg::K_EITHER;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slm_pkg::ST_IDLE:
            if (accept && req_data.last_item) state_in = slm_pkg::ST_START;
         slm_pkg::ST_START: begin
            unique case (cmd_ff)
               slm_pkg::CMD_ASK:          state_in = slm_pkg::ST_ASK;
               slm_pkg::CMD_REGISTER:     state_in = slm_pkg::ST_FINISH;
               slm_pkg::CMD_CLAIM_ALL,
               slm_pkg::CMD_CLAIM_FIRST,
               slm_pkg::CMD_CLAIM_EITHER,
               slm_pkg::CMD_RELEASE:      state_in = slm_pkg::ST_WLIST;
               slm_pkg::CMD_RELEASE_ALL:  state_in = slm_pkg::ST_SCAN_RD;
               slm_pkg::CMD_TIMER:
                  state_in = (wmode_ff[slot_ff] != slm_pkg::W_IDLE) ?
                             slm_pkg::ST_WLIST : slm_pkg::ST_FINISH;
            endcase
         end
         slm_pkg::ST_ASK:      state_in = slm_pkg::ST_FINISH;
         slm_pkg::ST_WLIST:
            state_in = (w_i_ff == w_n) ? slm_pkg::ST_PASS_END : slm_pkg::ST_WSEG;
         slm_pkg::ST_WSEG:
            state_in = (pass_ff == slm_pkg::P_LOCK) ? slm_pkg::ST_WLIST : slm_pkg::ST_WOWN;
         slm_pkg::ST_WOWN:
            state_in = walk_stop ? slm_pkg::ST_PASS_END : slm_pkg::ST_WLIST;
         slm_pkg::ST_PASS_END: begin
            unique case (pass_ff)
               slm_pkg::P_REL:   state_in = slm_pkg::ST_SLOT;
               slm_pkg::P_CHECK:
                  if (!hit_ff || (kind_ff == slm_pkg::K_EITHER && !w_half_ff))
                     state_in = slm_pkg::ST_WLIST;
                  else
                     state_in = slm_pkg::ST_CLAIM_DONE;
               slm_pkg::P_LOCK,
               slm_pkg::P_FIRST: state_in = slm_pkg::ST_CLAIM_DONE;
            endcase
         end
         slm_pkg::ST_CLAIM_DONE:
            state_in = (purpose_ff == slm_pkg::PU_REL) ? slm_pkg::ST_SLOT : slm_pkg::ST_FINISH;
         slm_pkg::ST_SLOT:
            if (k_ff == SCNT_W_L'(slm_pkg::SLOTS)) state_in = slm_pkg::ST_FINISH;
            else if (slot_cond)                   state_in = slm_pkg::ST_WLIST;
         slm_pkg::ST_SCAN_RD:  state_in = slm_pkg::ST_SCAN_EV;
         slm_pkg::ST_SCAN_EV:
            state_in = scan_end ? slm_pkg::ST_FINISH : slm_pkg::ST_SCAN_RD;
         slm_pkg::ST_FINISH:   state_in = slm_pkg::ST_IDLE;
      endcase
   end

   // memory requests and produced results
   always_comb begin
      own_port       = '0;
      lst_port       = '0;
      produce        = 1'b0;
      prod           = '0;
      prod.reply_tag = tag_ff;
      prod.status    = slm_pkg::STATUS_OK;

      lst_port.wr    = collect;
      lst_port.waddr = slm_pkg::list_addr(req_buf_ff, req_data.list_sel, sel_cnt);
      lst_port.wdata = req_data.segment;
      lst_port.raddr = slm_pkg::list_addr(w_buf_ff, w_half_ff, w_i_ff);

      unique case (state_ff)
         slm_pkg::ST_START: begin
            own_port.addr  = slm_pkg::seg_addr(seg_ff);
            own_port.wdata = own_ff;
            if (cmd_ff == slm_pkg::CMD_ASK) own_port.rd = 1'b1;
            if (cmd_ff == slm_pkg::CMD_REGISTER) begin
               own_port.wr = slm_pkg::seg_in_range(seg_ff);
               produce     = 1'b1;
            end
         end
         slm_pkg::ST_ASK: begin
            produce     = 1'b1;
            prod.status = (slm_pkg::seg_in_range(seg_ff) && own_rdata == 7'd0) ?
                          slm_pkg::STATUS_OK : slm_pkg::STATUS_FAIL;
         end
         slm_pkg::ST_WLIST:
            lst_port.rd = (w_i_ff != w_n);
         slm_pkg::ST_WSEG: begin
            own_port.addr  = slm_pkg::seg_addr(lst_rdata);
            own_port.wdata = w_own_ff;
            if (pass_ff == slm_pkg::P_LOCK) own_port.wr = slm_pkg::seg_in_range(lst_rdata);
            else                            own_port.rd = 1'b1;
         end
         slm_pkg::ST_WOWN: begin
            own_port.addr = slm_pkg::seg_addr(cur_seg_ff);
            if (pass_ff == slm_pkg::P_FIRST && seg_free) begin
               own_port.wr    = 1'b1;
               own_port.wdata = w_own_ff;
            end
            if (pass_ff == slm_pkg::P_REL && slm_pkg::seg_in_range(cur_seg_ff) &&
                own_rdata == w_own_ff) begin
               own_port.wr    = 1'b1;
               own_port.wdata = 7'd0;
            end
         end
         slm_pkg::ST_PASS_END:
            produce = (pass_ff == slm_pkg::P_REL);
         slm_pkg::ST_CLAIM_DONE: begin
            prod.has_value     = hasv_ff;
            prod.granted_value = val_ff;
            unique case (purpose_ff)
               slm_pkg::PU_REQ: begin
                  if (ok_ff) begin
                     produce = 1'b1;
                  end else if (to_ff) begin
                     produce          = 1'b1;
                     prod.start_timer = 1'b1;
                     prod.timer_slot  = 2'(slot_ff);
                     prod.timer_ticks = ticks_ff;
                  end
               end
               slm_pkg::PU_TMR: begin
                  produce        = 1'b1;
                  prod.reply_tag = wtag_ff[slot_ff];
                  prod.status    = ok_ff ? slm_pkg::STATUS_OK : slm_pkg::STATUS_FAIL;
               end
               default: begin
                  produce        = ok_ff;
                  prod.reply_tag = wtag_ff[kx];
               end
            endcase
         end
         slm_pkg::ST_SCAN_RD: begin
            own_port.rd   = 1'b1;
            own_port.addr = j_ff;
         end
         slm_pkg::ST_SCAN_EV: begin
            own_port.addr = j_ff;
            own_port.wr   = (own_rdata == own_ff);
            produce       = scan_end;
         end
         slm_pkg::ST_IDLE, slm_pkg::ST_SLOT, slm_pkg::ST_FINISH: ;
      endcase

      emit.valid = pend_v_ff && (produce || state_ff == slm_pkg::ST_FINISH);
      emit.data  = pend_ff;
      emit.data.last_result = (state_ff == slm_pkg::ST_FINISH);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= slm_pkg::ST_IDLE;
         req_buf_ff <= BW'(slm_pkg::SLOTS);
         req_cnt_ff <= '{default: '0};
         pend_v_ff  <= 1'b0;
         for (int s = 0; s < slm_pkg::SLOTS; s++) begin
            wmode_ff[s] <= slm_pkg::W_IDLE;
            wall_ff[s]  <= 1'b0;
            wown_ff[s]  <= 7'd0;
            wtag_ff[s]  <= 8'd0;
            wcnt_ff[s]  <= '{default: '0};
            wbuf_ff[s]  <= BW'(s);
         end
      end else begin
         state_ff <= state_in;
         if (collect) req_cnt_ff[req_data.list_sel] <= sel_cnt + CW'(1);
         if (produce)                            pend_v_ff <= 1'b1;
         else if (state_ff == slm_pkg::ST_FINISH) pend_v_ff <= 1'b0;
         if (state_ff == slm_pkg::ST_FINISH) req_cnt_ff <= '{default: '0};
         if (state_ff == slm_pkg::ST_SCAN_EV && scan_end) wmode_ff[slot_ff] <= slm_pkg::W_IDLE;
         if (state_ff == slm_pkg::ST_CLAIM_DONE) begin
            unique case (purpose_ff)
               slm_pkg::PU_REQ: begin
                  if (ok_ff) begin
                     wmode_ff[slot_ff] <= slm_pkg::W_IDLE;
                  end else begin
                     // park: the request buffer becomes the slot's, no copy
                     wall_ff[slot_ff]    <= (kind_ff != slm_pkg::K_FIRST);
                     if (kind_ff == slm_pkg::K_EITHER)
                        wmode_ff[slot_ff] <= to_ff ? slm_pkg::W_EITHER_TMR : slm_pkg::W_EITHER_REL;
                     else
                        wmode_ff[slot_ff] <= to_ff ? slm_pkg::W_TMR : slm_pkg::W_REL;
                     wown_ff[slot_ff]    <= own_ff;
                     wtag_ff[slot_ff]    <= tag_ff;
                     wcnt_ff[slot_ff][0] <= req_cnt_ff[0];
                     wcnt_ff[slot_ff][1] <= req_cnt_ff[1];
                     wbuf_ff[slot_ff]    <= req_buf_ff;
                     req_buf_ff          <= wbuf_ff[slot_ff];
                  end
               end
               slm_pkg::PU_TMR: wmode_ff[slot_ff] <= slm_pkg::W_IDLE;
               default: if (ok_ff) wmode_ff[kx] <= slm_pkg::W_IDLE;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (produce) pend_ff <= prod;
      unique case (state_ff)
         slm_pkg::ST_IDLE:
            if (accept && req_data.last_item) begin
               cmd_ff   <= slm_pkg::cmd_type'(req_data.cmd);
               to_ff    <= req_data.with_timeout;
               own_ff   <= req_data.train_owner;
               slot_ff  <= slm_pkg::slot_of(req_data.train_slot);
               tag_ff   <= req_data.requester;
               seg_ff   <= req_data.segment;
               ticks_ff <= req_data.timeout_ticks;
            end
         slm_pkg::ST_START: begin
            w_half_ff <= 1'b0;
            w_i_ff    <= '0;
            hit_ff    <= 1'b0;
            j_ff      <= '0;
            if (cmd_ff == slm_pkg::CMD_TIMER) begin
               w_buf_ff   <= wbuf_ff[slot_ff];
               w_na_ff    <= wcnt_ff[slot_ff][0];
               w_nb_ff    <= wcnt_ff[slot_ff][1];
               w_own_ff   <= wown_ff[slot_ff];
               kind_ff    <= slm_pkg::waiter_kind(wmode_ff[slot_ff], wall_ff[slot_ff]);
               pass_ff    <= (slm_pkg::waiter_kind(wmode_ff[slot_ff], wall_ff[slot_ff]) ==
                              slm_pkg::K_FIRST) ? slm_pkg::P_FIRST : slm_pkg::P_CHECK;
               purpose_ff <= slm_pkg::PU_TMR;
            end else begin
               w_buf_ff   <= req_buf_ff;
               w_na_ff    <= req_cnt_ff[0];
               w_nb_ff    <= req_cnt_ff[1];
               w_own_ff   <= own_ff;
               kind_ff    <= start_kind;
               purpose_ff <= slm_pkg::PU_REQ;
               if (cmd_ff == slm_pkg::CMD_RELEASE)            pass_ff <= slm_pkg::P_REL;
               else if (start_kind == slm_pkg::K_FIRST)       pass_ff <= slm_pkg::P_FIRST;
               else                                           pass_ff <= slm_pkg::P_CHECK;
            end
         end
         slm_pkg::ST_WSEG: begin
            cur_seg_ff <= lst_rdata;
            if (pass_ff == slm_pkg::P_LOCK) w_i_ff <= w_i_ff + CW'(1);
         end
         slm_pkg::ST_WOWN:
            if (walk_stop) hit_ff <= 1'b1;
            else           w_i_ff <= w_i_ff + CW'(1);
         slm_pkg::ST_PASS_END: begin
            ok_ff   <= 1'b0;
            hasv_ff <= 1'b0;
            val_ff  <= 7'd0;
            unique case (pass_ff)
               slm_pkg::P_CHECK:
                  if (!hit_ff) begin
                     pass_ff <= slm_pkg::P_LOCK;
                     w_i_ff  <= '0;
                  end else if (kind_ff == slm_pkg::K_EITHER && !w_half_ff) begin
                     // list A blocked: try list B
                     w_half_ff <= 1'b1;
                     w_i_ff    <= '0;
                     hit_ff    <= 1'b0;
                  end
               slm_pkg::P_LOCK: begin
                  ok_ff   <= 1'b1;
                  hasv_ff <= (kind_ff == slm_pkg::K_EITHER);
                  val_ff  <= (kind_ff == slm_pkg::K_EITHER) ? 7'(w_half_ff) : 7'd0;
               end
               slm_pkg::P_FIRST: begin
                  ok_ff   <= hit_ff;
                  hasv_ff <= hit_ff;
                  val_ff  <= hit_ff ? cur_seg_ff : 7'd0;
               end
               // start the waiter slot scan at slot zero
               slm_pkg::P_REL: k_ff <= '0;
            endcase
         end
         slm_pkg::ST_SLOT:
            if (k_ff != SCNT_W_L'(slm_pkg::SLOTS)) begin
               if (slot_cond) begin
                  w_buf_ff   <= wbuf_ff[kx];
                  w_na_ff    <= wcnt_ff[kx][0];
                  w_nb_ff    <= wcnt_ff[kx][1];
                  w_own_ff   <= wown_ff[kx];
                  kind_ff    <= slm_pkg::waiter_kind(wmode_ff[kx], wall_ff[kx]);
                  pass_ff    <= (slm_pkg::waiter_kind(wmode_ff[kx], wall_ff[kx]) ==
                                 slm_pkg::K_FIRST) ? slm_pkg::P_FIRST : slm_pkg::P_CHECK;
                  purpose_ff <= slm_pkg::PU_REL;
                  w_half_ff  <= 1'b0;
                  w_i_ff     <= '0;
                  hit_ff     <= 1'b0;
               end else begin
                  k_ff <= k_ff + SCNT_W_L'(1);
               end
            end
         slm_pkg::ST_CLAIM_DONE:
            if (purpose_ff == slm_pkg::PU_REL) k_ff <= k_ff + SCNT_W_L'(1);
         slm_pkg::ST_SCAN_EV:
            j_ff <= j_ff + slm_pkg::SEG_AW'(1);
         slm_pkg::ST_ASK, slm_pkg::ST_WLIST, slm_pkg::ST_SCAN_RD, slm_pkg::ST_FINISH: ;
      endcase
   end

endmodule

// ===== rtl/segment_lock_manager_top.sv =====
// Top level of the segment lock manager: sequencer, memories and result register.
//
// Items that are not the last of a request are taken one per cycle, back to back,
// while busy is low. The last item runs the command while busy is high: ask free
// reads the owner table and register writes it; a claim walks its lists, reading
// each segment checked from the list RAM, then its owner from the owner RAM, and
// each segment written from the list RAM; a release walks list A, then visits
// every waiter slot, with a full claim walk for each slot of another owner that
// waits for a release; release all scans the owner table and frees each segment
// of the owner. Results leave one per cycle on rsp_valid and must be taken when
// shown; the last result of a command, if any, appears in the cycle busy falls.
module segment_lock_manager_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  slm_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output slm_pkg::rsp_type rsp_data
);

   slm_pkg::rsp_emit_type  emit;
   slm_pkg::own_port_type  own_port;
   slm_pkg::list_port_type lst_port;
   logic [6:0]             own_rdata;
   logic [6:0]             lst_rdata;
   logic                   rsp_valid_ff;
   slm_pkg::rsp_type       rsp_data_ff;

   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .emit      (emit),
      .own_port  (own_port),
      .own_rdata (own_rdata),
      .lst_port  (lst_port),
      .lst_rdata (lst_rdata)
   );

   slm_owner_mem u_owner (
      .clock (clock),
      .reset (reset),
      .port  (own_port),
      .rdata (own_rdata)
   );

   slm_list_mem u_list (
      .clock (clock),
      .port  (lst_port),
      .rdata (lst_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= emit.valid;
   end

   always_ff @(posedge clock) begin
      if (emit.valid) rsp_data_ff <= emit.data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last_item |=> busy)
      else $error("final item did not start a command");

   a_collect_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.last_item |=> !busy)
      else $error("collected item left the block busy");

   a_timer_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.start_timer |-> rsp_data.last_result)
      else $error("timer start transaction not marked final");

endmodule
